FILE: sv/pwcs_pkg.sv
// pwcs_pkg: shared types, codes and defaults for the priority wait semaphore.
// Used by pwcs_ctrl and priority_wait_counting_semaphore. No dependencies.
package pwcs_pkg;

  localparam int MAX_WAITERS_DEF  = 8;
  localparam int TASK_ID_BITS_DEF = 8;

  // fixed field widths of the stream items
  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int PRIO_W    = 5;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int WAITERS_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_PEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_POST    = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOWAIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POSTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority;
    logic              no_wait;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 woken_valid;
    logic [ID_W-1:0]      woken_task_id;
    logic [PRIO_W-1:0]    woken_priority;
    logic [COUNT_W-1:0]   count_now;
    logic [WAITERS_W-1:0] waiters_now;
  } res_t;

  typedef struct packed {
    logic               load;        // start count written: reload count
    logic [COUNT_W-1:0] load_value;
    logic [COUNT_W-1:0] ceiling;
  } cfg_t;

endpackage

FILE: sv/pwcs_ram.sv
// pwcs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AddrW-1:0]       wr_addr,
  input  logic [Width-1:0]       wr_data,
  input  logic                   rd_en,
  input  logic [AddrW-1:0]       rd_addr,
  output logic [Width-1:0]       rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/pwcs_ctrl.sv
// pwcs_ctrl: sequencer, shared priority/id compare unit, count and wait list.
// Depends on pwcs_pkg and pwcs_ram.
module pwcs_ctrl #(
  parameter int MAX_WAITERS  = pwcs_pkg::MAX_WAITERS_DEF,
  parameter int TASK_ID_BITS = pwcs_pkg::TASK_ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pwcs_pkg::cfg_t cfg,
  input  logic           req_valid,
  input  pwcs_pkg::req_t req,
  output logic           ready,
  output logic           res_valid,
  output pwcs_pkg::res_t res,
  input  logic           res_take
);

  localparam int IdxW   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CntW   = $clog2(MAX_WAITERS + 1);
  localparam int IdW    = TASK_ID_BITS;
  localparam int DataW  = IdW + pwcs_pkg::PRIO_W;
  localparam int CountW = pwcs_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [pwcs_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [IdW-1:0]                id_r, id_nxt;
  logic [pwcs_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic                          nowait_r, nowait_nxt;
  logic [pwcs_pkg::COUNT_W-1:0]  sem_r, sem_nxt;
  logic [CntW-1:0]               total_r, total_nxt;
  logic [IdxW-1:0]               idx_r, idx_nxt;
  logic [IdxW-1:0]               best_idx_r, best_idx_nxt;
  logic [IdW-1:0]                best_id_r, best_id_nxt;
  logic [pwcs_pkg::PRIO_W-1:0]   best_prio_r, best_prio_nxt;
  logic [pwcs_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          wvalid_r, wvalid_nxt;

  logic                 rd_en, wr_en;
  logic [IdxW-1:0]      rd_addr, wr_addr;
  logic [DataW-1:0]     wr_data, rd_data;
  logic [IdW-1:0]       ent_id;
  logic [pwcs_pkg::PRIO_W-1:0] ent_prio;

  logic [IdW+pwcs_pkg::ID_W-1:0]      id_in_ext;
  logic [IdW+pwcs_pkg::ID_W-1:0]      wid_ext;
  logic [CntW+pwcs_pkg::WAITERS_W-1:0] tot_ext;
  logic [CntW:0]        total_ext, idx_p1, idx_p2, pos_p1;
  logic                 scan_last, take_best;
  logic [IdxW-1:0]      cand_idx, pos;
  logic                 do_remove;

  // low TASK_ID_BITS bits of the incoming id, zero-extended
  assign id_in_ext = {{IdW{1'b0}}, req.task_id};
  assign ent_id    = rd_data[IdW-1:0];
  assign ent_prio  = rd_data[DataW-1:IdW];
  assign total_ext = {1'b0, total_r};
  assign idx_p1    = (CntW+1)'(idx_r) + (CntW+1)'(1);
  assign idx_p2    = (CntW+1)'(idx_r) + (CntW+1)'(2);
  assign scan_last = (idx_p1 == total_ext);

  // shared compare unit: strict less keeps the oldest entry on ties
  assign take_best = (idx_r == '0) || (ent_prio < best_prio_r);
  assign cand_idx  = take_best ? idx_r : best_idx_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    nowait_nxt    = nowait_r;
    sem_nxt       = sem_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_prio_nxt = best_prio_r;
    status_nxt    = status_r;
    wvalid_nxt    = wvalid_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    do_remove     = 1'b0;
    pos           = idx_r;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req.opcode;
          id_nxt     = id_in_ext[IdW-1:0];
          prio_nxt   = req.task_priority;
          nowait_nxt = req.no_wait;
          wvalid_nxt = 1'b0;
          state_nxt  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_DONE;
        case (op_r)
          pwcs_pkg::OP_PEND: begin
            if (sem_r != '0) begin
              sem_nxt    = sem_r - CountW'(1);
              status_nxt = pwcs_pkg::ST_GRANTED;
            end else if (nowait_r) begin
              status_nxt = pwcs_pkg::ST_NOWAIT;
            end else if (total_r >= CntW'(MAX_WAITERS)) begin
              status_nxt = pwcs_pkg::ST_FULL;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = total_r[IdxW-1:0];
              wr_data    = {prio_r, id_r};
              total_nxt  = total_r + CntW'(1);
              status_nxt = pwcs_pkg::ST_QUEUED;
            end
          end
          pwcs_pkg::OP_POST: begin
            status_nxt = pwcs_pkg::ST_POSTED;
            if (total_r != '0) begin
              rd_en     = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end else if (sem_r < cfg.ceiling) begin
              sem_nxt = sem_r + CountW'(1);
            end
          end
          pwcs_pkg::OP_TIMEOUT: begin
            status_nxt = pwcs_pkg::ST_NOT_FOUND;
            if (total_r != '0) begin
              rd_en     = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            status_nxt = pwcs_pkg::ST_NOT_FOUND;
          end
        endcase
      end

      // one entry per cycle; rd_data holds entry idx_r
      S_SCAN: begin
        if (op_r == pwcs_pkg::OP_POST) begin
          best_idx_nxt = cand_idx;
          if (take_best) begin
            best_id_nxt   = ent_id;
            best_prio_nxt = ent_prio;
          end
          if (scan_last) begin
            do_remove  = 1'b1;
            pos        = cand_idx;
            wvalid_nxt = 1'b1;
          end
        end else if (ent_id == id_r) begin
          do_remove  = 1'b1;
          pos        = idx_r;
          status_nxt = pwcs_pkg::ST_REMOVED;
        end else if (scan_last) begin
          state_nxt = S_DONE;
        end
        if (!do_remove && !scan_last) begin
          rd_en   = 1'b1;
          rd_addr = idx_p1[IdxW-1:0];
          idx_nxt = idx_p1[IdxW-1:0];
        end
      end

      // close the gap: write entry k from k+1 while fetching k+2
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (idx_p2 < total_ext) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[IdxW-1:0];
          idx_nxt = idx_p1[IdxW-1:0];
        end else begin
          total_nxt = total_r - CntW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    pos_p1 = (CntW+1)'(pos) + (CntW+1)'(1);
    if (do_remove) begin
      if (pos_p1 < total_ext) begin
        rd_en     = 1'b1;
        rd_addr   = pos_p1[IdxW-1:0];
        idx_nxt   = pos;
        state_nxt = S_SHIFT;
      end else begin
        total_nxt = total_r - CntW'(1);
        state_nxt = S_DONE;
      end
    end

    if (cfg.load) begin
      sem_nxt = cfg.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sem_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      sem_r   <= sem_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    nowait_r    <= nowait_nxt;
    idx_r       <= idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_prio_r <= best_prio_nxt;
    status_r    <= status_nxt;
    wvalid_r    <= wvalid_nxt;
  end

  pwcs_ram #(
    .Width (DataW),
    .Depth (MAX_WAITERS)
  ) u_list (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wid_ext = {{pwcs_pkg::ID_W{1'b0}}, best_id_r};
  assign tot_ext = {{pwcs_pkg::WAITERS_W{1'b0}}, total_r};

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.status         = status_r;
    res.woken_valid    = wvalid_r;
    res.woken_task_id  = wvalid_r ? wid_ext[pwcs_pkg::ID_W-1:0] : '0;
    res.woken_priority = wvalid_r ? best_prio_r : '0;
    res.count_now      = sem_r;
    res.waiters_now    = tot_ext[pwcs_pkg::WAITERS_W-1:0];
  end

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(MAX_WAITERS))
    else $error("wait list count above capacity");

  a_grant_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && op_r == pwcs_pkg::OP_PEND && sem_r != '0 && !cfg.load)
    |=> (sem_r == $past(sem_r) - CountW'(1)))
    else $error("granted pend did not take one unit of the count");

  a_shift_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (total_ext >= (CntW+1)'(2)))
    else $error("shift with fewer than two waiters");
`endif

endmodule

FILE: sv/priority_wait_counting_semaphore.sv
// priority_wait_counting_semaphore: top level, stream ports, config regs, result register.
// Depends on pwcs_pkg and pwcs_ctrl (which holds pwcs_ram).

// Counting semaphore with a bounded wait list served by priority. A pend takes
// one unit of the count if it is above zero; otherwise it fails at once when
// no_wait is set, fails with "list full" when MAX_WAITERS tasks already wait,
// or else queues the task. A post wakes the waiting task with the lowest
// priority number (oldest on ties) and leaves the count alone; with nobody
// waiting it raises the count up to the ceiling. A timeout item removes the
// oldest waiting entry with the given id. Every accepted item gives exactly
// one result transfer. Items are handled one at a time: in_tready is low from
// the transfer until the result has been handed to the output register.
// A pend, or a post or timeout on an empty list, goes only through the decide
// and done states. A post or timeout over n waiters adds a scan of up to n
// entries plus a shift of each entry moved down to close the gap; the single
// read port of the wait-list RAM makes it read the entries one at a time. The
// output register lets the next item enter while a result still waits for
// out_tready. Writing the start count register (index 1) also reloads the
// count; the user must write configuration only while the block is idle, as
// the block itself does not enforce it.
module priority_wait_counting_semaphore #(
  parameter int MAX_WAITERS  = pwcs_pkg::MAX_WAITERS_DEF,
  parameter int TASK_ID_BITS = pwcs_pkg::TASK_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write port
  input  logic                           cfg_wr_en,
  input  logic [pwcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwcs_pkg::COUNT_W-1:0]   cfg_wdata,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] opcode, [9:2] task_id, [14:10] task_priority, [15] no_wait
  input  logic [15:0]                    in_tdata,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] status, [3] woken_valid, [11:4] woken_task_id, [16:12] woken_priority,
  // [32:17] count_now, [36:33] waiters_now, [39:37] zero
  output logic [39:0]                    out_tdata
);

  logic [pwcs_pkg::COUNT_W-1:0] ceiling_r;
  pwcs_pkg::cfg_t cfg;
  pwcs_pkg::req_t req;
  pwcs_pkg::res_t res;
  logic           ctrl_ready;
  logic           res_valid;
  logic           res_take;
  logic           out_tvalid_r;
  logic [39:0]    out_tdata_r;

  // ceiling register; the start count is not kept, it only reloads the count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= 16'd1;
    end else if (cfg_wr_en && cfg_index == pwcs_pkg::REG_CEILING) begin
      ceiling_r <= cfg_wdata;
    end
  end

  assign cfg.load       = cfg_wr_en && (cfg_index == pwcs_pkg::REG_START_COUNT);
  assign cfg.load_value = cfg_wdata;
  assign cfg.ceiling    = ceiling_r;

  assign req.opcode        = in_tdata[1:0];
  assign req.task_id       = in_tdata[9:2];
  assign req.task_priority = in_tdata[14:10];
  assign req.no_wait       = in_tdata[15];

  assign in_tready = ctrl_ready;

  pwcs_ctrl #(
    .MAX_WAITERS  (MAX_WAITERS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_tvalid && ctrl_ready),
    .req       (req),
    .ready     (ctrl_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // result moves into the output register whenever that register is free
  // or is being emptied by a transfer in the same cycle
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= {3'b000, res.waiters_now, res.count_now, res.woken_priority,
                      res.woken_task_id, res.woken_valid, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_woken_on_post: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[3]) |-> (out_tdata_r[2:0] == pwcs_pkg::ST_POSTED))
    else $error("woken task reported on a result that is not a post");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata_r)))
    else $error("result changed or dropped while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[39:37] == 3'b000))
    else $error("result padding bits not zero");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking regression for priority_wait_counting_semaphore.
// Needs pwcs_pkg and the block's RTL; no files or arguments are read.

// Flow: an initial block runs phases. Each phase waits until the block is idle,
// writes both registers and queues requests. A negedge driver presents them,
// and a posedge monitor does two things. It predicts the reply of every
// accepted request with a private copy of the semaphore, and it checks every
// reply transfer against the oldest prediction. Idle bursts on both sides vary
// the timing. One long sink hold-off fills the block up.
module tb;

  localparam int WL_DEPTH = pwcs_pkg::MAX_WAITERS_DEF;
  localparam int WL_IDX_W = (WL_DEPTH > 1) ? $clog2(WL_DEPTH) : 1;
  localparam int IdW      = pwcs_pkg::ID_W;
  localparam int PrioW    = pwcs_pkg::PRIO_W;
  localparam int CountW   = pwcs_pkg::COUNT_W;
  // no function, reports not found
  localparam logic [pwcs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_wr_en = 1'b0;
  logic [pwcs_pkg::CFG_IDX_W-1:0] cfg_index = pwcs_pkg::REG_CEILING;
  logic [pwcs_pkg::COUNT_W-1:0]   cfg_wdata = '0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [1:0] opcode, [9:2] task_id, [14:10] task_priority, [15] no_wait
  logic [15:0] in_tdata = '0;

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [2:0] status, [3] woken_valid, [11:4] woken_task_id, [16:12] woken_priority,
  // [32:17] count_now, [36:33] waiters_now, [39:37] zero
  logic [39:0] out_tdata;

  priority_wait_counting_semaphore u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Semaphore predictor: count, ceiling and the wait list in arrival order.
  // ---------------------------------------------------------------------------
  logic [pwcs_pkg::COUNT_W-1:0]   sem_cnt = '0;
  logic [pwcs_pkg::COUNT_W-1:0]   sem_max = 16'd1;
  logic [pwcs_pkg::ID_W-1:0]      wl_id   [WL_DEPTH];
  logic [pwcs_pkg::PRIO_W-1:0]    wl_prio [WL_DEPTH];
  logic [pwcs_pkg::WAITERS_W-1:0] wl_n = '0;

  // Take entry pos off the list and close the gap.
  function automatic void wl_remove(int pos);
    for (int k = pos; k + 1 < wl_n; k++) begin
      wl_id[WL_IDX_W'(k)]   = wl_id[WL_IDX_W'(k + 1)];
      wl_prio[WL_IDX_W'(k)] = wl_prio[WL_IDX_W'(k + 1)];
    end
    wl_n--;
  endfunction

  // Apply one request to the predicted state and return the reply it gives.
  function automatic pwcs_pkg::res_t semaphore_apply(logic [15:0] d);
    pwcs_pkg::res_t              r;
    logic [pwcs_pkg::OP_W-1:0]   op;
    logic [pwcs_pkg::ID_W-1:0]   id;
    logic [pwcs_pkg::PRIO_W-1:0] pr;
    logic                        nw;
    int                          pick;
    bit                          found;
    op = d[1:0];
    id = d[9:2];
    pr = d[14:10];
    nw = d[15];
    r = '0;
    r.status = pwcs_pkg::ST_NOT_FOUND;
    found = 1'b0;
    case (op)
      pwcs_pkg::OP_PEND: begin
        if (sem_cnt != '0) begin
          sem_cnt--;
          r.status = pwcs_pkg::ST_GRANTED;
        end else if (nw) begin
          r.status = pwcs_pkg::ST_NOWAIT;
        end else if (wl_n >= WL_DEPTH) begin
          r.status = pwcs_pkg::ST_FULL;
        end else begin
          wl_id[wl_n[WL_IDX_W-1:0]]   = id;
          wl_prio[wl_n[WL_IDX_W-1:0]] = pr;
          wl_n++;
          r.status = pwcs_pkg::ST_QUEUED;
        end
      end
      pwcs_pkg::OP_POST: begin
        r.status = pwcs_pkg::ST_POSTED;
        if (wl_n != '0) begin
          // most urgent = lowest number; strict < keeps the oldest on ties
          pick = 0;
          for (int i = 1; i < wl_n; i++)
            if (wl_prio[WL_IDX_W'(i)] < wl_prio[WL_IDX_W'(pick)]) pick = i;
          r.woken_valid    = 1'b1;
          r.woken_task_id  = wl_id[WL_IDX_W'(pick)];
          r.woken_priority = wl_prio[WL_IDX_W'(pick)];
          wl_remove(pick);
        end else if (sem_cnt < sem_max) begin
          sem_cnt++;
        end
      end
      pwcs_pkg::OP_TIMEOUT: begin
        for (int i = 0; i < wl_n && !found; i++) begin
          if (wl_id[WL_IDX_W'(i)] == id) begin
            wl_remove(i);
            r.status = pwcs_pkg::ST_REMOVED;
            found = 1'b1;
          end
        end
      end
      default: ;  // unused opcode: state untouched, not found
    endcase
    r.count_now   = sem_cnt;
    r.waiters_now = wl_n;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by the processes
  // ---------------------------------------------------------------------------
  logic [15:0]    req_q[$];    // requests waiting for the driver
  pwcs_pkg::res_t reply_q[$];  // predicted replies, oldest first
  int reqs_queued = 0;
  int reqs_taken  = 0;
  int errors      = 0;
  bit req_fire    = 1'b0;   // input transfer at the last rising edge
  bit idle_on     = 1'b1;
  bit hold_go     = 1'b0;
  bit sink_hold   = 1'b0;
  int src_gap     = 0;
  int sink_gap    = 0;

  function automatic void note_err(string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void queue_req(logic [pwcs_pkg::OP_W-1:0] op,
                                    logic [pwcs_pkg::ID_W-1:0] id,
                                    logic [pwcs_pkg::PRIO_W-1:0] pr, logic nw);
    req_q.push_back({nw, pr, id, op});
    reqs_queued++;
  endfunction

  // Mostly pends and posts so the list fills and drains. Ids come from a
  // small pool so that timeouts find their entry and duplicates occur.
  function automatic void queue_random();
    logic [pwcs_pkg::OP_W-1:0]   op;
    logic [pwcs_pkg::ID_W-1:0]   id;
    logic [pwcs_pkg::PRIO_W-1:0] pr;
    logic                        nw;
    int                          roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      op = pwcs_pkg::OP_PEND;
    else if (roll < 75) op = pwcs_pkg::OP_POST;
    else if (roll < 95) op = pwcs_pkg::OP_TIMEOUT;
    else                op = OP_UNUSED;
    if ($urandom_range(0, 9) < 7) id = IdW'($urandom_range(0, 7));
    else                          id = IdW'($urandom);
    if ($urandom_range(0, 1) == 0) pr = PrioW'($urandom_range(0, 3));  // force ties
    else                           pr = PrioW'($urandom);
    nw = ($urandom_range(0, 6) == 0);
    queue_req(op, id, pr, nw);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: new values at the falling edge, one item held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tdata  <= req_q.pop_front();
        in_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 17);
      end
    end
  end

  // Reply sink: random ready bursts, plus the long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n || sink_hold) begin
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 6) == 0) sink_gap = $urandom_range(1, 17);
    end
  end

  // Long sink stall, counted at rising edges: the block fills and drops in_tready
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check reply transfers, predict accepted request transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    pwcs_pkg::res_t got;
    pwcs_pkg::res_t want;
    string          bad;
    req_fire = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status         = out_tdata[2:0];
        got.woken_valid    = out_tdata[3];
        got.woken_task_id  = out_tdata[11:4];
        got.woken_priority = out_tdata[16:12];
        got.count_now      = out_tdata[32:17];
        got.waiters_now    = out_tdata[36:33];
        if (reply_q.size() == 0) begin
          note_err($sformatf("reply transfer with nothing pending: %h", out_tdata));
        end else begin
          want = reply_q.pop_front();
          bad = "";
          if (got.status         !== want.status)         bad = {bad, " status"};
          if (got.woken_valid    !== want.woken_valid)    bad = {bad, " woken_valid"};
          if (got.woken_task_id  !== want.woken_task_id)  bad = {bad, " woken_task_id"};
          if (got.woken_priority !== want.woken_priority) bad = {bad, " woken_priority"};
          if (got.count_now      !== want.count_now)      bad = {bad, " count_now"};
          if (got.waiters_now    !== want.waiters_now)    bad = {bad, " waiters_now"};
          if (bad != "")
            note_err($sformatf({"mismatch in%s: exp st=%0d wv=%b id=%h pr=%0d cnt=%0d",
                                " n=%0d / got st=%0d wv=%b id=%h pr=%0d cnt=%0d n=%0d"},
                               bad, want.status, want.woken_valid, want.woken_task_id,
                               want.woken_priority, want.count_now, want.waiters_now,
                               got.status, got.woken_valid, got.woken_task_id,
                               got.woken_priority, got.count_now, got.waiters_now));
        end
      end
      if (in_tvalid && in_tready) begin
        req_fire = 1'b1;
        reply_q.push_back(semaphore_apply(in_tdata));
        reqs_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Idle = every queued request taken and every reply received.
  task automatic wait_drained();
    @(negedge clk);
    while (reqs_taken != reqs_queued || reply_q.size() != 0) @(negedge clk);
  endtask

  // Drain, program ceiling and count, then queue n random requests.
  task automatic run_phase(input logic [pwcs_pkg::COUNT_W-1:0] mx,
                           input logic [pwcs_pkg::COUNT_W-1:0] init,
                           input int n, input bit idle, input bit hold);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= pwcs_pkg::REG_CEILING;
    cfg_wdata <= mx;
    @(negedge clk);
    cfg_index <= pwcs_pkg::REG_START_COUNT;
    cfg_wdata <= init;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sem_max = mx;
    sem_cnt = init;  // the start count write reloads the count
    idle_on = idle;
    if (hold) hold_go = 1'b1;
    repeat (n) queue_random();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ceiling 3, count 0
    run_phase(16'd3, 16'd0, 0, 1'b1, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'h00, 5'd0, 1'b1);     // count 0 and no-wait: fails
    queue_req(pwcs_pkg::OP_PEND, 8'hFF, 5'd31, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'h00, 5'd0, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'hAA, 5'd5, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'h55, 5'd5, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'hAA, 5'd5, 1'b0);     // same id queued twice
    queue_req(pwcs_pkg::OP_PEND, 8'h12, 5'd31, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'h34, 5'd0, 1'b0);     // ties with id 00
    queue_req(pwcs_pkg::OP_PEND, 8'h77, 5'd16, 1'b0);    // list now full
    queue_req(pwcs_pkg::OP_PEND, 8'h99, 5'd1, 1'b0);     // list full
    queue_req(pwcs_pkg::OP_PEND, 8'h99, 5'd1, 1'b1);     // no-wait wins over full
    queue_req(pwcs_pkg::OP_TIMEOUT, 8'hAA, 5'd0, 1'b0);  // removes the older AA only
    queue_req(pwcs_pkg::OP_TIMEOUT, 8'h3C, 5'd0, 1'b0);  // unknown id
    queue_req(pwcs_pkg::OP_POST, 8'h00, 5'd0, 1'b0);     // wakes 00, oldest of prio 0
    queue_req(pwcs_pkg::OP_POST, 8'h00, 5'd0, 1'b0);     // wakes 34
    queue_req(OP_UNUSED, 8'hFF, 5'd31, 1'b1);
    // empty the list; count untouched
    repeat (5) queue_req(pwcs_pkg::OP_POST, 8'h00, 5'd0, 1'b0);
    // count up to 3, last one capped
    repeat (4) queue_req(pwcs_pkg::OP_POST, 8'h00, 5'd0, 1'b0);
    queue_req(pwcs_pkg::OP_PEND, 8'h01, 5'd2, 1'b1);     // count available: granted
    queue_req(pwcs_pkg::OP_TIMEOUT, 8'h01, 5'd0, 1'b0);  // empty list

    // Random phases over several register settings
    run_phase(16'd1, 16'd0, 64, 1'b1, 1'b1);             // reset values, long sink stall
    run_phase(16'd0, 16'd0, 64, 1'b1, 1'b0);             // zero ceiling
    run_phase(16'hFFFF, 16'hFFFF, 64, 1'b1, 1'b0);
    run_phase(16'd4, 16'd6, 64, 1'b1, 1'b0);             // start above the ceiling
    run_phase(16'hFFFF, 16'd0, 64, 1'b1, 1'b0);
    run_phase(CountW'($urandom_range(1, 8)), CountW'($urandom_range(0, 1)), 64,
              1'b1, 1'b0);
    run_phase(16'd2, 16'd1, 64, 1'b0, 1'b0);             // no idling at the end

    wait_drained();
    repeat (40) @(posedge clk);  // catch stray replies
    if (errors == 0)
      $display("priority_wait_counting_semaphore regression: pass");
    else
      $display("priority_wait_counting_semaphore regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("priority_wait_counting_semaphore regression: fail");
    $finish;
  end

endmodule
